[rtl/core/cpsb_pkg.sv]
// cpsb_pkg: shared widths, register indexes, op codes and item types
// for the clipped palette sprite blit unit. No dependencies.

package cpsb_pkg;

    localparam int POS_W     = 16;  // sprite position registers, signed
    localparam int DIM_W     = 13;  // width and clip registers
    localparam int IDX_W     = 8;   // source pixel / palette index
    localparam int COLOR_W   = 16;
    localparam int COORD_W   = 12;  // destination coordinates
    localparam int CFG_W     = 16;  // widest register
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_HI  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE = 3'd7;

    // item op codes
    localparam logic OP_PAL_WRITE = 1'b0;
    localparam logic OP_PIXEL     = 1'b1;

    typedef struct packed {
        logic               op;
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] entry_color;
        logic               first;
    } t_pix_in;

    typedef struct packed {
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [COLOR_W-1:0] pixel_color;
    } t_pix_out;

endpackage

[rtl/core/cpsb_stream_if.sv]
// cpsb_stream_if: valid/ready channel carrying one item of type t_payload.
// No dependencies; the payload type is given where the channel is instantiated.

interface cpsb_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/cpsb_ram.sv]
// cpsb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module cpsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/clipped_palette_sprite_blit_unit.sv]
// clipped_palette_sprite_blit_unit: palette sprite blitter with clip window
// and colour key. Uses cpsb_pkg, cpsb_stream_if and cpsb_ram.
//
//  channel  dir  modport  payload    carries
//  i_pix    in   sink     t_pix_in   palette writes and source pixels
//  o_pix    out  source   t_pix_out  destination x, y and palette colour
//  i_cfg_*  in   -        16 bit     register writes, no read-back
//
// one item accepted per clock while i_pix.ready is high; a pixel's result passes
// through the palette RAM read at acceptance, then the output register.
// throughput is set by the single palette RAM read port, one lookup a cycle.
// reset is synchronous and active low; palette contents are undefined until loaded.
// a stalled output holds the output register and stage one; i_pix.ready
// falls only when both are full and o_pix is not ready.

module clipped_palette_sprite_blit_unit #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_DIM         = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cpsb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cpsb_pkg::CFG_W-1:0]     i_cfg_wdata,
    cpsb_stream_if.sink                    i_pix,
    cpsb_stream_if.source                  o_pix
);
    import cpsb_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int EW = (DW > DIM_W) ? DW : DIM_W;
    localparam int SW = ((CW > POS_W - 1) ? CW : POS_W - 1) + 2;

    // configuration
    logic [POS_W-1:0] r_pos_x;
    logic [POS_W-1:0] r_pos_y;
    logic [DIM_W-1:0] r_src_width;
    logic [DIM_W-1:0] r_clip_x_lo;
    logic [DIM_W-1:0] r_clip_x_hi;
    logic [DIM_W-1:0] r_clip_y_lo;
    logic [DIM_W-1:0] r_clip_y_hi;
    logic             r_key_enable;

    // raster counters
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;

    // stage one (palette read in flight) and output register
    logic               r_s1_v;
    logic [COORD_W-1:0] r_s1_dx;
    logic [COORD_W-1:0] r_s1_dy;
    logic               r_s1_hit;
    logic               n_s1_v;
    logic               r_o_v;
    t_pix_out           r_o_data;

    logic               w_adv;
    logic               w_acc;
    logic               w_pix;
    logic               w_in_range;
    logic               w_keep;
    logic [CW-1:0]      w_col;
    logic [CW-1:0]      w_row;
    logic [EW-1:0]      w_width;
    logic signed [SW-1:0] w_dx;
    logic signed [SW-1:0] w_dy;
    logic               w_inside;
    logic               w_keyed;
    logic [COLOR_W-1:0] w_rdata;

    function automatic logic [EW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        return (ext > EW'(MAX_DIM)) ? EW'(MAX_DIM) : ext;
    endfunction

    function automatic logic signed [SW-1:0] to_signed(input logic [EW-1:0] v);
        return $signed({{(SW - EW){1'b0}}, v});
    endfunction

    // handshake
    assign w_adv       = !r_o_v || o_pix.ready;
    assign i_pix.ready = !r_s1_v || w_adv;
    assign w_acc       = i_pix.valid && i_pix.ready;
    assign w_pix       = w_acc && (i_pix.payload.op == OP_PIXEL);
    assign w_in_range  = {1'b0, i_pix.payload.index} < (IDX_W + 1)'(PALETTE_ENTRIES);

    // coordinate, clip and key
    assign w_col   = i_pix.payload.first ? '0 : r_col;
    assign w_row   = i_pix.payload.first ? '0 : r_row;
    assign w_width = (r_src_width == '0) ? EW'(1) : clamp_dim(r_src_width);

    assign w_dx = $signed({{(SW - POS_W){r_pos_x[POS_W-1]}}, r_pos_x})
                + $signed({{(SW - CW){1'b0}}, w_col});
    assign w_dy = $signed({{(SW - POS_W){r_pos_y[POS_W-1]}}, r_pos_y})
                + $signed({{(SW - CW){1'b0}}, w_row});

    assign w_inside = (w_dx >= to_signed(clamp_dim(r_clip_x_lo)))
                   && (w_dx <  to_signed(clamp_dim(r_clip_x_hi)))
                   && (w_dy >= to_signed(clamp_dim(r_clip_y_lo)))
                   && (w_dy <  to_signed(clamp_dim(r_clip_y_hi)));
    assign w_keyed = r_key_enable && (i_pix.payload.index == '0);
    assign w_keep  = w_inside && !w_keyed;

    always_comb begin
        if ((EW'(w_col) + EW'(1)) >= w_width) begin
            n_col = '0;
            n_row = ((EW'(w_row) + EW'(1)) >= EW'(MAX_DIM)) ? '0 : w_row + CW'(1);
        end else begin
            n_col = w_col + CW'(1);
            n_row = w_row;
        end
    end

    always_comb begin
        if (w_acc) begin
            n_s1_v = w_pix && w_keep;
        end else if (w_adv) begin
            n_s1_v = 1'b0;
        end else begin
            n_s1_v = r_s1_v;
        end
    end

    cpsb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_acc && (i_pix.payload.op == OP_PAL_WRITE) && w_in_range),
        .i_waddr (i_pix.payload.index[AW-1:0]),
        .i_wdata (i_pix.payload.entry_color),
        .i_re    (w_pix),
        .i_raddr (i_pix.payload.index[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_src_width  <= DIM_W'(1);
            r_clip_x_lo  <= '0;
            r_clip_x_hi  <= DIM_W'(4096);
            r_clip_y_lo  <= '0;
            r_clip_y_hi  <= DIM_W'(4096);
            r_key_enable <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_s1_v       <= 1'b0;
            r_o_v        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POS_X:      r_pos_x      <= i_cfg_wdata[POS_W-1:0];
                    REG_POS_Y:      r_pos_y      <= i_cfg_wdata[POS_W-1:0];
                    REG_SRC_WIDTH:  r_src_width  <= i_cfg_wdata[DIM_W-1:0];
                    REG_CLIP_X_LO:  r_clip_x_lo  <= i_cfg_wdata[DIM_W-1:0];
                    REG_CLIP_X_HI:  r_clip_x_hi  <= i_cfg_wdata[DIM_W-1:0];
                    REG_CLIP_Y_LO:  r_clip_y_lo  <= i_cfg_wdata[DIM_W-1:0];
                    REG_CLIP_Y_HI:  r_clip_y_hi  <= i_cfg_wdata[DIM_W-1:0];
                    REG_KEY_ENABLE: r_key_enable <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            // counters move on every pixel, dropped or not
            if (w_pix) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_v <= n_s1_v;
            if (w_adv) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_pix) begin
            r_s1_dx  <= w_dx[COORD_W-1:0];
            r_s1_dy  <= w_dy[COORD_W-1:0];
            r_s1_hit <= w_in_range;
        end
        if (w_adv && r_s1_v) begin
            r_o_data.dest_x      <= r_s1_dx;
            r_o_data.dest_y      <= r_s1_dy;
            r_o_data.pixel_color <= r_s1_hit ? w_rdata : '0;
        end
    end

    assign o_pix.valid   = r_o_v;
    assign o_pix.payload = r_o_data;

    // a palette write never leaves anything in stage one
    a_pal_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_pix.payload.op == OP_PAL_WRITE)) |=> !r_s1_v)
        else $error("palette write produced a pending result");

    // nothing taken while both stages are full and the output is stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_o_v && !o_pix.ready) |-> !w_acc)
        else $error("item accepted into a full pipeline");

    // output valid only rises from a filled stage one
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_v) |-> $past(r_s1_v))
        else $error("output valid without a stage one item");

endmodule
